// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL modules of the preorder walk core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/btpre_pkg.sv -----
// Types and fixed constants of the binary tree preorder walk core.
`timescale 1ns / 1ps

package btpre_pkg;

   // Fixed bounds of the walk.
   localparam int STACK_CAP = 16;
   localparam int RESULT_CAP = 16;
   localparam int STK_IDX_W = $clog2(STACK_CAP);
   localparam int DEPTH_W = $clog2(STACK_CAP + 1);
   localparam int COUNT_W = $clog2(RESULT_CAP + 1);

   // One node as it arrives on the request channel.
   typedef struct packed {
      logic [7:0] node_value;
      logic       left_present;
      logic [3:0] left_child;
      logic       right_present;
      logic [3:0] right_child;
      logic       final_node;
   } req_type;

   // One visited node on the response channel.
   typedef struct packed {
      logic [7:0] visit_value;
      logic [3:0] visit_index;
      logic       walk_end;
   } rsp_type;

   // One entry of the node table.
   typedef struct packed {
      logic [7:0] value;
      logic       left_present;
      logic [3:0] left_child;
      logic       right_present;
      logic [3:0] right_child;
   } node_type;

   // Operations of the shared modular adder.
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB_LEFT,
      ST_SUB_RIGHT,
      ST_FETCH,
      ST_VISIT
   } state_type;

endpackage

// ----- rtl/binary_tree_preorder_stack_core.sv -----
// Top level of the binary tree preorder walk core.
`timescale 1ns / 1ps
// Usage:
// The request channel takes one tree node per transaction, in index order from 0.
// A transaction is accepted at a rising edge with start high and busy low.
// Each node is written to the node table and its index sum folded into the root
// index in steps: the accept cycle, then the shared modular adder subtracts a present
// left child and then a present right child; busy stays high until those steps are done.
// Once the table holds MAX_NODES nodes, further nodes are dropped; only final_node sets busy.
// The node flagged final_node starts the walk: after its adder steps (with no adder steps
// when the table was already full) the first table read is issued, and each visited
// node then passes through a fetch state (one registered node table read) and a visit
// state that pushes the children.
// Results appear on rsp_item for one cycle each, marked by rsp_strobe, one per
// visited node; walk_end marks the last one. The walk stops when the stack empties
// or after 16 results. The receiver cannot stall the response channel.
// For final_node, busy stays high from the accept edge until the last result appears.
// Reset (synchronous, active high) empties the table count, the root sum and the
// stack; node table and stack contents are not cleared.
module binary_tree_preorder_stack_core #(
   parameter int MAX_NODES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  btpre_pkg::req_type req_item,
   output logic               rsp_strobe,
   output btpre_pkg::rsp_type rsp_item
);
   import btpre_pkg::*;

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);

   // Registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic [IDX_W-1:0]   root_ff, root_in;
   req_type            item_ff, item_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   node_type           rd_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   // Node table and walk stack.
   node_type           node_table [MAX_NODES];
   logic [IDX_W-1:0]   stack_ff [STACK_CAP];

   // Child index reduction table, worked out at elaboration.
   logic [IDX_W-1:0]   wrap_lut [16];

   // Control and datapath signals.
   logic               accept;
   logic               table_we;
   alu_op_type         alu_op;
   logic [IDX_W-1:0]   alu_a;
   logic [IDX_W-1:0]   alu_b;
   logic [IDX_W-1:0]   alu_y;
   logic [IDX_W-1:0]   left_wrap;
   logic [IDX_W-1:0]   right_wrap;
   logic               push_right;
   logic               push_left;
   logic [DEPTH_W-1:0] depth_1;
   logic [DEPTH_W-1:0] depth_2;
   logic [DEPTH_W-1:0] depth_top;
   logic [COUNT_W-1:0] count_1;
   logic               last_visit;

   for (genvar g = 0; g < 16; g++) begin : g_wrap
      assign wrap_lut[g] = IDX_W'(g % MAX_NODES);
   end

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_item_ff;

   // Shared modular adder operand selection.
   always_comb begin
      alu_op = ALU_ADD;
      alu_a = root_ff;
      alu_b = loaded_ff[IDX_W-1:0];
      case (state_ff)
         ST_SUB_LEFT: begin
            alu_op = ALU_SUB;
            alu_b = wrap_lut[item_ff.left_child];
         end
         ST_SUB_RIGHT: begin
            alu_op = ALU_SUB;
            alu_b = wrap_lut[item_ff.right_child];
         end
         default: begin
            alu_op = ALU_ADD;
         end
      endcase
   end

   btpre_mod_unit #(
      .MAX_NODES (MAX_NODES)
   ) u_mod_unit (
      .op        (alu_op),
      .operand_a (alu_a),
      .operand_b (alu_b),
      .result    (alu_y)
   );

   // Child pushes of the node under visit.
   always_comb begin
      left_wrap = wrap_lut[rd_ff.left_child];
      right_wrap = wrap_lut[rd_ff.right_child];
      push_right = rd_ff.right_present && (depth_ff < DEPTH_W'(STACK_CAP));
      depth_1 = depth_ff + DEPTH_W'(push_right);
      push_left = rd_ff.left_present && (depth_1 < DEPTH_W'(STACK_CAP));
      depth_2 = depth_1 + DEPTH_W'(push_left);
      depth_top = depth_ff - DEPTH_W'(1);
      count_1 = count_ff + COUNT_W'(1);
      last_visit = (depth_2 == '0) || (count_1 == COUNT_W'(RESULT_CAP));
   end

   // Sequencer: next state and register inputs.
   always_comb begin
      state_in = state_ff;
      loaded_in = loaded_ff;
      root_in = root_ff;
      item_in = item_ff;
      depth_in = depth_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in = rsp_item_ff;
      table_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_item;
               if (loaded_ff < CNT_W'(MAX_NODES)) begin
                  table_we = 1'b1;
                  root_in = alu_y;
                  loaded_in = loaded_ff + CNT_W'(1);
                  state_in = ST_SUB_LEFT;
               end else if (req_item.final_node) begin
                  idx_in = root_ff;
                  depth_in = '0;
                  count_in = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SUB_LEFT: begin
            if (item_ff.left_present) begin
               root_in = alu_y;
            end
            state_in = ST_SUB_RIGHT;
         end
         ST_SUB_RIGHT: begin
            if (item_ff.right_present) begin
               root_in = alu_y;
            end
            if (item_ff.final_node) begin
               idx_in = item_ff.right_present ? alu_y : root_ff;
               depth_in = '0;
               count_in = '0;
               state_in = ST_FETCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_VISIT;
         end
         ST_VISIT: begin
            rsp_strobe_in = 1'b1;
            rsp_item_in.visit_value = rd_ff.value;
            rsp_item_in.visit_index = 4'(idx_ff);
            rsp_item_in.walk_end = last_visit;
            if (last_visit) begin
               loaded_in = '0;
               root_in = '0;
               depth_in = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               // Pop the new top right away; a just pushed child is never stored long.
               count_in = count_1;
               depth_in = depth_2 - DEPTH_W'(1);
               if (push_left) begin
                  idx_in = left_wrap;
               end else if (push_right) begin
                  idx_in = right_wrap;
               end else begin
                  idx_in = stack_ff[depth_top[STK_IDX_W-1:0]];
               end
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         loaded_ff <= '0;
         root_ff <= '0;
         depth_ff <= '0;
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         loaded_ff <= loaded_in;
         root_ff <= root_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff <= idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Node table: written on load, read with a registered output.
   always_ff @(posedge clock) begin
      if (table_we) begin
         node_table[loaded_ff[IDX_W-1:0]] <= '{
            value:         req_item.node_value,
            left_present:  req_item.left_present,
            left_child:    req_item.left_child,
            right_present: req_item.right_present,
            right_child:   req_item.right_child
         };
      end
      rd_ff <= node_table[idx_ff];
   end

   // Walk stack: right child goes below the left child.
   always_ff @(posedge clock) begin
      if (state_ff == ST_VISIT) begin
         if (push_right) begin
            stack_ff[depth_ff[STK_IDX_W-1:0]] <= right_wrap;
         end
         if (push_left) begin
            stack_ff[depth_1[STK_IDX_W-1:0]] <= left_wrap;
         end
      end
   end

   // Checks on the sequencer and the walk.
   `ASSERT_IMPLY(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_W'(STACK_CAP))
   `ASSERT_IMPLY(a_root_range, clock, reset, 1'b1, 32'(root_ff) < MAX_NODES)
   `ASSERT_IMPLY(a_idle_clean, clock, reset, state_ff == ST_IDLE, depth_ff == '0 && count_ff == '0)
   `ASSERT_IMPLY(a_strobe_src, clock, reset, rsp_strobe_ff, $past(state_ff == ST_VISIT))
   `ASSERT_NEXT(a_end_quiet, clock, reset, rsp_strobe_ff && rsp_item_ff.walk_end, !rsp_strobe_ff)

endmodule

// ----- rtl/btpre_mod_unit.sv -----
// Shared modular add/subtract unit for table indices.
`timescale 1ns / 1ps

module btpre_mod_unit #(
   parameter int MAX_NODES = 16
) (
   input  btpre_pkg::alu_op_type           op,
   input  logic [$clog2(MAX_NODES)-1:0]    operand_a,
   input  logic [$clog2(MAX_NODES)-1:0]    operand_b,
   output logic [$clog2(MAX_NODES)-1:0]    result
);
   import btpre_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam logic [IDX_W:0] MOD_VAL = (IDX_W + 1)'(MAX_NODES);

   logic [IDX_W:0] sum;
   logic [IDX_W:0] diff;
   logic [IDX_W:0] sum_wrap;
   logic [IDX_W:0] diff_wrap;

   // Both operands are below the modulus, so one correction step suffices.
   always_comb begin
      sum = {1'b0, operand_a} + {1'b0, operand_b};
      diff = {1'b0, operand_a} - {1'b0, operand_b};
      sum_wrap = (sum >= MOD_VAL) ? (sum - MOD_VAL) : sum;
      diff_wrap = diff[IDX_W] ? (diff + MOD_VAL) : diff;
   end

   // Select the requested operation.
   always_comb begin
      unique case (op)
         ALU_ADD: result = sum_wrap[IDX_W-1:0];
         ALU_SUB: result = diff_wrap[IDX_W-1:0];
         default: result = sum_wrap[IDX_W-1:0];
      endcase
   end

endmodule
